// ----- rtl/core/spectrometer_channel_calibration_macros.svh -----
// spectrometer_channel_calibration_macros.svh
// Assertion macros shared by the calibration core; no dependencies.
`ifndef SPECTROMETER_CHANNEL_CALIBRATION_MACROS_SVH
`define SPECTROMETER_CHANNEL_CALIBRATION_MACROS_SVH

// ante in one cycle implies cons in the next, outside reset
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// a cycle in reset implies cons in the next
`define SCC_ASSERT_RST(lbl, clk, rst_n, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/scc_pkg.sv -----
// scc_pkg.sv
// Constants, lookup tables and pipeline types of the channel calibration core.
// No dependencies.
package scc_pkg;

  localparam int CHANNELS = 512;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] MODE_RAW    = 2'd0;
  localparam logic [1:0] MODE_KELVIN = 2'd1;
  localparam logic [1:0] MODE_FLUX   = 2'd2;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // exponent limits, Q3.12
  localparam int         QUOT_W   = 15;
  localparam logic [14:0] X_LOW    = 15'd1761;
  localparam logic [14:0] X_HIGH_K = 15'd25805;
  localparam logic [14:0] X_HIGH_F = 15'd23142;

  localparam logic [19:0] C40_LOG2 = 20'd789132;
  localparam logic [19:0] C45_LOG2 = 20'd887774;

  localparam logic [22:0] L2_BIAS_K = 23'd262144;   // 4.0 in Q.16
  localparam logic [22:0] L2_BIAS_F = 23'd2097152;  // 32.0 in Q.16

  localparam logic signed [37:0] T_MIN = 38'sd43;   // 2.7 K in Q.4

  localparam logic signed [61:0] FLUX_FLOOR = -62'sd38654705664;  // -9.0 in Q.32
  localparam logic signed [61:0] FLUX_BIAS  = 62'sd42949672960;   // 10.0 in Q.32

  // round(65536 * 10^(i/16))
  localparam logic [19:0] POW_FRAC_TAB [17] = '{
    20'd65536,  20'd75680,  20'd87393,  20'd100921, 20'd116541, 20'd134580,
    20'd155410, 20'd179465, 20'd207243, 20'd239321, 20'd276363, 20'd319139,
    20'd368536, 20'd425579, 20'd491451, 20'd567518, 20'd655360
  };

  localparam logic [23:0] POW_INT_TAB [8] = '{
    24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000,
    24'd10000000
  };

  // round(65536 * log2(1 + i/16))
  localparam logic [16:0] LOG_FRAC_TAB [17] = '{
    17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
    17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
    17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

  typedef struct packed {
    logic       valid;
    logic [7:0] code;
    logic [8:0] chan;
    logic       fof;
  } scc_tag_t;

  typedef struct packed {
    scc_tag_t    tag;
    logic [23:0] gain;
    logic [23:0] bg;
    logic [14:0] high;
    logic        sat_hi;
    logic        sat_lo;
  } scc_side_t;

endpackage

// ----- rtl/core/scc_in_if.sv -----
// scc_in_if.sv
// Request channel into the calibration core: handshake plus load/sample payload.
// No dependencies.
interface scc_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [8:0]         channel;
  logic [7:0]         sample_code;
  logic signed [15:0] coef_offset;
  logic [15:0]        coef_slope;
  logic [23:0]        coef_gain;
  logic [23:0]        coef_background;
  logic               first_of_frame;

  modport source (
    output valid, action, channel, sample_code, coef_offset, coef_slope,
           coef_gain, coef_background, first_of_frame,
    input  ready
  );
  modport sink (
    input  valid, action, channel, sample_code, coef_offset, coef_slope,
           coef_gain, coef_background, first_of_frame,
    output ready
  );
endinterface

// ----- rtl/core/scc_out_if.sv -----
// scc_out_if.sv
// Pixel channel out of the calibration core: handshake plus pixel payload.
// No dependencies.
interface scc_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] pixel_value;
  logic [8:0] pixel_channel;
  logic       frame_start;

  modport source (output valid, pixel_value, pixel_channel, frame_start, input ready);
  modport sink   (input valid, pixel_value, pixel_channel, frame_start, output ready);
endinterface

// ----- rtl/core/scc_div.sv -----
// scc_div.sv
// Pipelined restoring divider for the exponent, one quotient bit per stage.
// Depends on scc_pkg.
module scc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [30:0]       in_dvd,
  input  logic [15:0]       in_dvs,
  input  scc_pkg::scc_side_t in_side,
  output logic [14:0]       out_q,
  output scc_pkg::scc_side_t out_side
);
  import scc_pkg::*;

  logic [30:0] rem_r  [QUOT_W];
  logic [15:0] dvs_r  [QUOT_W];
  logic [14:0] q_r    [QUOT_W];
  scc_side_t   side_r [QUOT_W];

  for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
    localparam int BIT = QUOT_W - 1 - j;
    logic [30:0] rem_in;
    logic [15:0] dvs_in;
    logic [14:0] q_in;
    scc_side_t   side_in;
    logic [30:0] shifted;
    logic        ge;

    if (j == 0) begin : g_first
      assign rem_in  = in_dvd;
      assign dvs_in  = in_dvs;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign dvs_in  = dvs_r[j-1];
      assign q_in    = q_r[j-1];
      assign side_in = side_r[j-1];
    end

    assign shifted = 31'(dvs_in) << BIT;
    assign ge      = rem_in >= shifted;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[j].tag.valid <= 1'b0;
      end else if (en) begin
        side_r[j]   <= side_in;
        dvs_r[j]    <= dvs_in;
        rem_r[j]    <= ge ? rem_in - shifted : rem_in;
        q_r[j]      <= q_in | (15'(ge) << BIT);
      end
    end
  end

  assign out_q    = q_r[QUOT_W-1];
  assign out_side = side_r[QUOT_W-1];

endmodule

// ----- rtl/core/scc_log2.sv -----
// scc_log2.sv
// Pipelined log2 in Q.16: leading-one normalize over six stages, then table
// lookup with linear interpolation. Depends on scc_pkg.
module scc_log2 (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [63:0]      in_v,
  input  scc_pkg::scc_tag_t in_tag,
  output logic [22:0]      out_l2,
  output scc_pkg::scc_tag_t out_tag
);
  import scc_pkg::*;

  localparam int NORM_STAGES = 6;

  logic [63:0] n_r [NORM_STAGES];
  logic [5:0]  z_r [NORM_STAGES];
  scc_tag_t    t_r [NORM_STAGES];

  for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic [63:0] n_in;
    logic [5:0]  z_in;
    scc_tag_t    t_in;

    if (j == 0) begin : g_first
      assign n_in = in_v;
      assign z_in = '0;
      assign t_in = in_tag;
    end else begin : g_next
      assign n_in = n_r[j-1];
      assign z_in = z_r[j-1];
      assign t_in = t_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        t_r[j].valid <= 1'b0;
      end else if (en) begin
        t_r[j] <= t_in;
        if (n_in[63 -: SH] == '0) begin
          n_r[j] <= n_in << SH;
          z_r[j] <= z_in + 6'(SH);
        end else begin
          n_r[j] <= n_in;
          z_r[j] <= z_in;
        end
      end
    end
  end

  // mantissa sits just below the leading one at bit 63
  logic [63:0] n_fin;
  logic [4:0]  idx_lo, idx_hi;
  logic [16:0] lf_lo, lf_diff;
  logic [28:0] lf_prod;

  assign n_fin   = n_r[NORM_STAGES-1];
  assign idx_lo  = {1'b0, n_fin[62:59]};
  assign idx_hi  = idx_lo + 5'd1;
  assign lf_lo   = LOG_FRAC_TAB[idx_lo];
  assign lf_diff = LOG_FRAC_TAB[idx_hi] - lf_lo;
  assign lf_prod = 29'(lf_diff) * 29'(n_fin[58:47]);

  logic [5:0]  p1_r;
  logic [16:0] base1_r;
  logic [28:0] prod1_r;
  scc_tag_t    t1_r;
  logic [22:0] l2_r;
  scc_tag_t    t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r.valid <= 1'b0;
      t2_r.valid <= 1'b0;
    end else if (en) begin
      t1_r    <= t_r[NORM_STAGES-1];
      p1_r    <= 6'd63 - z_r[NORM_STAGES-1];
      base1_r <= lf_lo;
      prod1_r <= lf_prod;
      t2_r    <= t1_r;
      l2_r    <= 23'({p1_r, 16'h0000}) + 23'(base1_r) + 23'(prod1_r[28:12]);
    end
  end

  assign out_l2  = l2_r;
  assign out_tag = t2_r;

endmodule

// ----- rtl/core/spectrometer_channel_calibration.sv -----
// Per-channel calibration of 8-bit log-detector spectrometer samples. Load
// requests write one channel's offset, slope, gain and background into two
// coefficient memories and produce no pixel; sample requests read their
// channel's entry and produce one pixel in the mode held in cal_mode (raw
// code, Kelvin log scale or flux log scale). The core accepts one request
// per clock while the output is not stalled, and each sample passes in
// order through the coefficient read, the exponent numerator, the
// bit-per-stage divider, the power of ten with the temperature or flux,
// the log2 unit and the stages that scale and saturate. The whole pipeline
// advances on one enable set by the output register, so a stalled pixel
// holds every stage. A sample of a channel that was never loaded gives an
// undefined pixel in the log modes. Change cal_mode only while no request
// is in flight.
`include "spectrometer_channel_calibration_macros.svh"

module spectrometer_channel_calibration (
  input  logic       clk,
  input  logic       rst_n,
  scc_in_if.sink     in_ch,
  scc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);
  import scc_pkg::*;

  logic [1:0] cal_mode_r;
  logic       is_kelvin;
  logic       en;
  logic       in_fire;
  logic       in_range;
  logic [CH_W-1:0] addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_mode_r <= MODE_RAW;
    end else if (cfg_we) begin
      cal_mode_r <= cfg_wdata;
    end
  end

  assign is_kelvin = (cal_mode_r == MODE_KELVIN);

  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && en;
  assign addr        = CH_W'(in_ch.channel);
  assign in_range    = 32'(in_ch.channel) < 32'(CHANNELS);

  // Coefficient memories. Loads and samples share one port, one request a
  // cycle unless stalled, so a following sample reads the newly loaded entry.
  logic [31:0] os_mem [CHANNELS];
  logic [47:0] gb_mem [CHANNELS];
  logic [31:0] os_rd_r;
  logic [47:0] gb_rd_r;
  logic        range_r;
  scc_tag_t    s0_tag_r;

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.action == ACT_LOAD && in_range) begin
      os_mem[addr] <= {in_ch.coef_offset, in_ch.coef_slope};
      gb_mem[addr] <= {in_ch.coef_gain, in_ch.coef_background};
    end
    if (in_fire) begin
      os_rd_r <= os_mem[addr];
      gb_rd_r <= gb_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_tag_r.valid <= 1'b0;
    end else if (en) begin
      s0_tag_r.valid <= in_fire && in_ch.action == ACT_SAMPLE;
      s0_tag_r.code  <= in_ch.sample_code;
      s0_tag_r.chan  <= in_ch.channel;
      s0_tag_r.fof   <= in_ch.first_of_frame;
      range_r        <= in_range;
    end
  end

  // exponent numerator and saturation flags
  logic signed [15:0] c_offset;
  logic [15:0]        c_slope;
  logic [23:0]        c_gain, c_bg;
  logic signed [17:0] num;
  logic               num_pos, ovf, slope0;
  scc_side_t          s1_side_nxt;

  assign c_offset = range_r ? $signed(os_rd_r[31:16]) : 16'sd0;
  assign c_slope  = range_r ? os_rd_r[15:0] : 16'd0;
  assign c_gain   = range_r ? gb_rd_r[47:24] : 24'd0;
  assign c_bg     = range_r ? gb_rd_r[23:0] : 24'd0;
  assign num      = $signed({2'b00, s0_tag_r.code, 8'h00}) - 18'(c_offset);
  assign num_pos  = !num[17] && (num != 18'sd0);
  // quotient reaches 8.0 or more exactly when num >= 8 * slope
  assign ovf      = {3'b000, num[16:0]} >= {1'b0, c_slope, 3'b000};
  assign slope0   = (c_slope == 16'd0);

  always_comb begin
    s1_side_nxt.tag    = s0_tag_r;
    s1_side_nxt.gain   = c_gain;
    s1_side_nxt.bg     = c_bg;
    s1_side_nxt.high   = is_kelvin ? X_HIGH_K : X_HIGH_F;
    s1_side_nxt.sat_hi = slope0 || (num_pos && ovf);
    s1_side_nxt.sat_lo = !slope0 && !num_pos;
  end

  scc_side_t   s1_side_r;
  logic [30:0] s1_dvd_r;
  logic [15:0] s1_dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.tag.valid <= 1'b0;
    end else if (en) begin
      s1_side_r <= s1_side_nxt;
      s1_dvd_r  <= num_pos ? 31'({num[16:0], 12'h000}) : 31'd0;
      s1_dvs_r  <= c_slope;
    end
  end

  logic [14:0] div_q;
  scc_side_t   div_side;

  scc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_dvd   (s1_dvd_r),
    .in_dvs   (s1_dvs_r),
    .in_side  (s1_side_r),
    .out_q    (div_q),
    .out_side (div_side)
  );

  // clamp exponent
  logic [14:0] x_nxt;
  always_comb begin
    if (div_side.sat_hi)          x_nxt = div_side.high;
    else if (div_side.sat_lo)     x_nxt = X_LOW;
    else if (div_q < X_LOW)       x_nxt = X_LOW;
    else if (div_q > div_side.high) x_nxt = div_side.high;
    else                          x_nxt = div_q;
  end

  // 10^x: fractional table with interpolation, then integer decade
  logic [14:0] x_r;
  scc_tag_t    x_tag_r;
  logic [23:0] x_gain_r, x_bg_r;
  logic [4:0]  pf_lo_idx, pf_hi_idx;
  logic [19:0] pf_lo, pf_diff, m_nxt;
  logic [27:0] pf_prod;

  assign pf_lo_idx = {1'b0, x_r[11:8]};
  assign pf_hi_idx = pf_lo_idx + 5'd1;
  assign pf_lo     = POW_FRAC_TAB[pf_lo_idx];
  assign pf_diff   = POW_FRAC_TAB[pf_hi_idx] - pf_lo;
  assign pf_prod   = 28'(pf_diff) * 28'(x_r[7:0]);
  assign m_nxt     = pf_lo + pf_prod[27:8];

  logic [19:0] m_r;
  logic [2:0]  k_r;
  scc_tag_t    e1_tag_r, e2_tag_r, e3_tag_r, e4_tag_r, e5_tag_r;
  logic [23:0] e1_gain_r, e1_bg_r, e2_gain_r, e2_bg_r, e3_gain_r, e3_bg_r;
  logic [43:0] e_prod;
  logic [39:0] e_r;
  logic [48:0] kp_r;
  logic signed [36:0] d16_r;
  logic [36:0] tk_r;
  logic signed [61:0] s_r;
  logic [63:0] v_r;

  logic signed [41:0] d16_full;
  logic signed [37:0] t_full;
  logic signed [61:0] s_nxt, s_clamped, w;

  assign e_prod   = 44'(m_r) * 44'(POW_INT_TAB[k_r]);
  assign d16_full = $signed({2'b00, e_r}) - $signed({6'b000000, e2_bg_r, 12'h000});
  assign t_full   = $signed({1'b0, kp_r[48:12]}) - $signed({14'd0, e3_bg_r});
  assign s_nxt    = $signed({1'b0, e3_gain_r}) * d16_r;
  assign s_clamped = (s_r < FLUX_FLOOR) ? FLUX_FLOOR : s_r;
  assign w        = s_clamped + FLUX_BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_tag_r.valid  <= 1'b0;
      e1_tag_r.valid <= 1'b0;
      e2_tag_r.valid <= 1'b0;
      e3_tag_r.valid <= 1'b0;
      e4_tag_r.valid <= 1'b0;
      e5_tag_r.valid <= 1'b0;
    end else if (en) begin
      x_tag_r   <= div_side.tag;
      x_gain_r  <= div_side.gain;
      x_bg_r    <= div_side.bg;
      x_r       <= x_nxt;

      e1_tag_r  <= x_tag_r;
      e1_gain_r <= x_gain_r;
      e1_bg_r   <= x_bg_r;
      m_r       <= m_nxt;
      k_r       <= x_r[14:12];

      e2_tag_r  <= e1_tag_r;
      e2_gain_r <= e1_gain_r;
      e2_bg_r   <= e1_bg_r;
      e_r       <= e_prod[39:0];

      e3_tag_r  <= e2_tag_r;
      e3_gain_r <= e2_gain_r;
      e3_bg_r   <= e2_bg_r;
      kp_r      <= 49'(e_r) * 49'(290);
      // in flux mode 10^x stays below 2^35, so 37 bits hold the difference
      d16_r     <= 37'(d16_full);

      e4_tag_r  <= e3_tag_r;
      tk_r      <= (t_full < T_MIN) ? 37'(T_MIN) : t_full[36:0];
      s_r       <= s_nxt;

      e5_tag_r  <= e4_tag_r;
      v_r       <= is_kelvin ? 64'(tk_r) : 64'(w);
    end
  end

  logic [22:0] lg_l2;
  scc_tag_t    lg_tag;

  scc_log2 u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v_r),
    .in_tag  (e5_tag_r),
    .out_l2  (lg_l2),
    .out_tag (lg_tag)
  );

  // scale to pixel units, round in Kelvin mode, saturate
  logic [22:0] l2b_r;
  logic [42:0] pp_r;
  scc_tag_t    l3_tag_r, l4_tag_r;
  logic [43:0] rounded;
  logic [8:0]  pix_nxt;
  logic [8:0]  out_pixel_r, out_chan_r;
  logic        out_fof_r;

  assign rounded = is_kelvin ? 44'(pp_r) + (44'd1 << 31) : 44'(pp_r);

  always_comb begin
    case (cal_mode_r) inside
      MODE_KELVIN, MODE_FLUX: begin
        pix_nxt = (rounded[43:32] > 12'd511) ? 9'd511 : rounded[40:32];
      end
      default: begin
        pix_nxt = {1'b0, l4_tag_r.code};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l3_tag_r.valid <= 1'b0;
      l4_tag_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else if (en) begin
      l3_tag_r    <= lg_tag;
      l2b_r       <= lg_l2 - (is_kelvin ? L2_BIAS_K : L2_BIAS_F);
      l4_tag_r    <= l3_tag_r;
      pp_r        <= 43'(l2b_r) * 43'(is_kelvin ? C40_LOG2 : C45_LOG2);
      out_valid_r <= l4_tag_r.valid;
      out_pixel_r <= pix_nxt;
      out_chan_r  <= l4_tag_r.chan;
      out_fof_r   <= l4_tag_r.fof;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_value   = out_pixel_r;
  assign out_ch.pixel_channel = out_chan_r;
  assign out_ch.frame_start   = out_fof_r;

  // raw mode may sample unloaded channels, so check the exponent in log modes only
  logic log_mode;
  assign log_mode = (cal_mode_r == MODE_KELVIN) || (cal_mode_r == MODE_FLUX);

  `SCC_ASSERT_RST(a_reset_empty, clk, rst_n, !out_ch.valid, "pixel valid after reset")
  `SCC_ASSERT_NEXT(a_load_silent, clk, rst_n, in_fire && in_ch.action == ACT_LOAD, !s0_tag_r.valid, "load request entered the pixel pipeline")
  `SCC_ASSERT_NEXT(a_x_range, clk, rst_n, en && log_mode && div_side.tag.valid, x_tag_r.valid && x_r >= X_LOW && x_r <= X_HIGH_K, "exponent outside clamp range")

endmodule
